@@ rtl/core/spa_pkg.sv @@
// Shared types and constants of the slot pool page allocator.
// No dependencies.
`default_nettype none
package spa_pkg;

  localparam int SPA_MAX_SLOTS = 256;
  localparam int CW            = 9;   // counts: live, free stack depth, bump
  localparam int NW            = 8;   // slot number
  localparam int AW            = 32;  // byte address
  localparam int SW            = 17;  // slot stride in bytes
  localparam int RW            = SW + NW; // remainder during address lookup
  localparam int CFG_IW        = 2;

  localparam logic [CFG_IW-1:0] REG_PAGE_BASE = 2'd0;
  localparam logic [CFG_IW-1:0] REG_ITEM_SIZE = 2'd1;
  localparam logic [CFG_IW-1:0] REG_ALIGN     = 2'd2;
  localparam logic [CFG_IW-1:0] REG_CAPACITY  = 2'd3;

  typedef enum logic [3:0] {
    OP_ALLOC       = 4'd0,
    OP_FREE_ADDR   = 4'd1,
    OP_FREE_INDEX  = 4'd2,
    OP_GET         = 4'd3,
    OP_INDEX_OF    = 4'd4,
    OP_MARK        = 4'd5,
    OP_SWEEP       = 4'd6,
    OP_FREE_MARKED = 4'd7,
    OP_RESET       = 4'd8,
    OP_INFO        = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_ADDR  = 3'd2,
    ST_NOT_ALLOC = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef struct packed {
    logic latch;
    logic dispatch;
    logic div_step;
    logic exec;
    logic mul;
    logic sweep_step;
    logic finish;
  } spa_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       div_last;
    logic       sweep_done;
  } spa_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/spa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/spa_ctrl.sv @@
// Sequencer of the slot pool page allocator: steps one operation through
// dispatch, lookup division, execution, address multiply or sweep. Uses spa_pkg.
`default_nettype none
module spa_ctrl
  import spa_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire spa_stat_t stat,
  output spa_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_DIV, S_EXEC, S_MUL, S_SWEEP, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        case (stat.op) inside
          OP_FREE_ADDR, OP_INDEX_OF, OP_MARK: state_nxt = S_DIV;
          OP_SWEEP, OP_FREE_MARKED:           state_nxt = S_SWEEP;
          default:                            state_nxt = S_EXEC;
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_SWEEP: begin
        if (stat.sweep_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && state_r == S_DISPATCH)
    else $error("accepted word did not enter dispatch");

  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> !busy)
    else $error("controller did not return to idle after finish");

endmodule
`default_nettype wire

@@ rtl/core/spa_dp.sv @@
// Datapath of the slot pool page allocator: configuration, used and mark bits,
// counters, free stack RAM, lookup divider and result registers. Uses spa_pkg.
`default_nettype none
module spa_dp
  import spa_pkg::*;
#(
  parameter int MAX_SLOTS = SPA_MAX_SLOTS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [3:0]        in_operation,
  input  wire logic [AW-1:0]     in_address,
  input  wire logic [NW-1:0]     in_slot_index,
  input  wire logic              cfg_valid,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [AW-1:0]     cfg_data,
  input  wire spa_cmd_t          cmd,
  output spa_stat_t              stat,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [NW-1:0]          out_slot_number,
  output logic [AW-1:0]          out_slot_address,
  output logic [CW-1:0]          out_freed_count,
  output logic [CW-1:0]          out_live_count,
  output logic [CW-1:0]          out_free_count
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_SLOTS);

  // configuration
  logic [AW-1:0] base_r;
  logic [15:0]   item_r;
  logic [3:0]    align_r;
  logic [CW-1:0] capcfg_r;

  // control state
  logic [MAX_SLOTS-1:0] used_r, used_nxt, mark_r, mark_nxt;
  logic [CW-1:0] depth_r, depth_nxt, bump_r, bump_nxt, live_r, live_nxt;
  logic [2:0]    cnt_r;
  logic          out_valid_r;

  // per-operation payload
  logic [3:0]    op_r;
  logic [AW-1:0] off_r;
  logic [NW-1:0] sidx_r;
  logic [RW-1:0] rem_r;
  logic [NW-1:0] q_r;
  logic [SW-1:0] stride_r;
  logic [AW-1:0] span_r;
  logic [CW-1:0] cap_r;
  logic [CW-1:0] lim_r, ptr_r;
  logic [NW-1:0] idx_r, idx_nxt, num_r, num_nxt;
  logic [2:0]    stat_r, stat_nxt;
  logic          addr_en_r, addr_en_nxt;
  logic [CW-1:0] freed_r, freed_nxt;
  logic [RW-1:0] prod_r;

  logic [2:0]    o_status_r;
  logic [NW-1:0] o_num_r;
  logic [AW-1:0] o_addr_r;
  logic [CW-1:0] o_freed_r, o_live_r, o_free_r;

  // free stack
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [NW-1:0] ram_rdata;

  // stride and capacity from configuration
  logic [SW-1:0] sz17, amask, stride_c;
  logic [3:0]    al_c;
  logic [CW-1:0] cap_c;

  always_comb begin
    sz17     = (item_r == 16'd0) ? SW'(1) : SW'(item_r);
    al_c     = (align_r > 4'd12) ? 4'd12 : align_r;
    amask    = (SW'(1) << al_c) - SW'(1);
    stride_c = (sz17 + amask) & ~amask;
    if (capcfg_r == '0) begin
      cap_c = CW'(1);
    end else if (capcfg_r > MAX_C) begin
      cap_c = MAX_C;
    end else begin
      cap_c = capcfg_r;
    end
  end

  // divider step: trial subtract of stride shifted by the current quotient bit
  logic [RW-1:0] trial;
  logic          take;
  assign trial = RW'(stride_r) << (3'd7 - cnt_r);
  assign take  = (rem_r >= trial);

  // shared look-up of one used and mark bit
  logic [CW-1:0] look_idx;
  logic          look_ok, used_at, mark_at, loc_ok;

  always_comb begin
    case (op_r) inside
      OP_SWEEP, OP_FREE_MARKED:     look_idx = ptr_r;
      OP_FREE_INDEX, OP_GET:        look_idx = CW'(sidx_r);
      default:                      look_idx = CW'(q_r);
    endcase
    look_ok = (look_idx < MAX_C);
    used_at = look_ok && used_r[look_idx[IW-1:0]];
    mark_at = look_ok && mark_r[look_idx[IW-1:0]];
    loc_ok  = (off_r < span_r) && (rem_r == '0) && (CW'(q_r) < bump_r) &&
              (CW'(q_r) < MAX_C);
  end

  logic          rel_en;
  logic [IW-1:0] rel_i;
  logic [CW-1:0] live_dec, a_idx;

  always_comb begin
    used_nxt    = used_r;
    mark_nxt    = mark_r;
    depth_nxt   = depth_r;
    bump_nxt    = bump_r;
    live_nxt    = live_r;
    idx_nxt     = idx_r;
    num_nxt     = num_r;
    stat_nxt    = stat_r;
    addr_en_nxt = addr_en_r;
    freed_nxt   = freed_r;
    rel_en      = 1'b0;
    rel_i       = look_idx[IW-1:0];
    ram_we      = 1'b0;
    ram_waddr   = depth_r[IW-1:0];
    live_dec    = '0;
    a_idx       = '0;

    if (cmd.latch) begin
      num_nxt     = '0;
      stat_nxt    = ST_OK;
      addr_en_nxt = 1'b0;
      freed_nxt   = '0;
    end

    if (cmd.exec) begin
      case (op_r)
        OP_ALLOC: begin
          if (live_r >= cap_r) begin
            stat_nxt = ST_FULL;
          end else begin
            if (depth_r != '0) begin
              depth_nxt = depth_r - CW'(1);
              a_idx     = CW'(ram_rdata);
            end else begin
              a_idx    = bump_r;
              bump_nxt = bump_r + CW'(1);
            end
            if (a_idx >= MAX_C) begin
              stat_nxt = ST_FULL;
            end else begin
              used_nxt[a_idx[IW-1:0]] = 1'b1;
              mark_nxt[a_idx[IW-1:0]] = 1'b0;
              live_nxt    = live_r + CW'(1);
              num_nxt     = a_idx[NW-1:0];
              idx_nxt     = a_idx[NW-1:0];
              addr_en_nxt = 1'b1;
            end
          end
        end
        OP_FREE_ADDR: begin
          if (!loc_ok) begin
            stat_nxt = ST_BAD_ADDR;
          end else if (!used_at) begin
            stat_nxt = ST_NOT_ALLOC;
          end else begin
            rel_en  = 1'b1;
            num_nxt = q_r;
          end
        end
        OP_FREE_INDEX, OP_GET: begin
          if (CW'(sidx_r) >= cap_r || CW'(sidx_r) >= bump_r) begin
            stat_nxt = ST_RANGE;
          end else if (!used_at) begin
            stat_nxt = ST_NOT_ALLOC;
          end else begin
            num_nxt = sidx_r;
            idx_nxt = sidx_r;
            if (op_r == OP_FREE_INDEX) begin
              rel_en = 1'b1;
            end else begin
              addr_en_nxt = 1'b1;
            end
          end
        end
        OP_INDEX_OF, OP_MARK: begin
          if (!loc_ok || !used_at) begin
            stat_nxt = ST_BAD_ADDR;
          end else begin
            num_nxt = q_r;
            if (op_r == OP_MARK) begin
              mark_nxt[look_idx[IW-1:0]] = 1'b1;
            end
          end
        end
        OP_RESET: begin
          freed_nxt = live_r;
          used_nxt  = '0;
          mark_nxt  = '0;
          depth_nxt = '0;
          bump_nxt  = '0;
          live_nxt  = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.sweep_step && used_at) begin
      if (op_r == OP_SWEEP) begin
        if (mark_at) begin
          mark_nxt[look_idx[IW-1:0]] = 1'b0;
        end else begin
          rel_en    = 1'b1;
          freed_nxt = freed_r + CW'(1);
        end
      end else if (mark_at) begin
        rel_en    = 1'b1;
        freed_nxt = freed_r + CW'(1);
      end
    end

    // release one slot; the last one empties the page
    if (rel_en) begin
      used_nxt[rel_i] = 1'b0;
      mark_nxt[rel_i] = 1'b0;
      live_dec = (live_r != '0) ? live_r - CW'(1) : '0;
      live_nxt = live_dec;
      if (live_dec == '0) begin
        used_nxt  = '0;
        mark_nxt  = '0;
        depth_nxt = '0;
        bump_nxt  = '0;
      end else if (depth_r < MAX_C) begin
        ram_we    = 1'b1;
        depth_nxt = depth_r + CW'(1);
      end
    end
  end

  spa_ram #(.WIDTH(NW), .DEPTH(MAX_SLOTS)) u_free_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (NW'(rel_i)),
    .raddr (IW'(depth_r - CW'(1))),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      item_r      <= 16'd16;
      align_r     <= 4'd4;
      capcfg_r    <= 9'd256;
      used_r      <= '0;
      mark_r      <= '0;
      depth_r     <= '0;
      bump_r      <= '0;
      live_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_PAGE_BASE: base_r   <= cfg_data;
          REG_ITEM_SIZE: item_r   <= cfg_data[15:0];
          REG_ALIGN:     align_r  <= cfg_data[3:0];
          REG_CAPACITY:  capcfg_r <= cfg_data[CW-1:0];
          default: begin
          end
        endcase
      end
      used_r      <= used_nxt;
      mark_r      <= mark_nxt;
      depth_r     <= depth_nxt;
      bump_r      <= bump_nxt;
      live_r      <= live_nxt;
      out_valid_r <= cmd.finish;
      if (cmd.latch) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    stride_r  <= stride_c;
    span_r    <= AW'(RW'(stride_c) * RW'(cap_c));
    cap_r     <= cap_c;
    idx_r     <= idx_nxt;
    num_r     <= num_nxt;
    stat_r    <= stat_nxt;
    addr_en_r <= addr_en_nxt;
    freed_r   <= freed_nxt;
    if (cmd.latch) begin
      op_r   <= in_operation;
      off_r  <= in_address - base_r;
      rem_r  <= RW'(in_address - base_r);
      sidx_r <= in_slot_index;
      q_r    <= '0;
    end
    if (cmd.dispatch) begin
      lim_r <= (bump_r > MAX_C) ? MAX_C : bump_r;
      ptr_r <= '0;
    end
    if (cmd.div_step) begin
      q_r <= {q_r[NW-2:0], take};
      if (take) begin
        rem_r <= rem_r - trial;
      end
    end
    if (cmd.sweep_step) begin
      ptr_r <= ptr_r + CW'(1);
    end
    if (cmd.mul) begin
      prod_r <= RW'(idx_r) * RW'(stride_r);
    end
    if (cmd.finish) begin
      o_status_r <= stat_r;
      o_num_r    <= num_r;
      o_addr_r   <= addr_en_r ? base_r + AW'(prod_r) : '0;
      o_freed_r  <= freed_r;
      o_live_r   <= live_r;
      o_free_r   <= depth_r;
    end
  end

  assign stat.op         = op_r;
  assign stat.div_last   = (cnt_r == 3'd7);
  assign stat.sweep_done = (ptr_r >= lim_r);

  assign out_valid        = out_valid_r;
  assign out_status       = o_status_r;
  assign out_slot_number  = o_num_r;
  assign out_slot_address = o_addr_r;
  assign out_freed_count  = o_freed_r;
  assign out_live_count   = o_live_r;
  assign out_free_count   = o_free_r;

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= MAX_C)
    else $error("live count above slot limit");

  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r + live_r) == bump_r)
    else $error("free stack plus live slots differ from bump index");

endmodule
`default_nettype wire

@@ rtl/core/slot_pool_page_allocator.sv @@
// Slot pool page allocator. Alloc, free/get by index, reset and info go through
// dispatch, execution, address multiply and finish; free by address, index of and
// mark add the one-bit-per-cycle lookup divider; sweep and free marked step one
// slot a cycle over min(bump, slots) slots. One operation at a time: busy drops
// in the strobe's cycle, when the next word can go in; the receiver cannot stall.
// Synchronous reset empties the page and loads register defaults.
`default_nettype none
module slot_pool_page_allocator
  import spa_pkg::*;
#(
  parameter int MAX_SLOTS = SPA_MAX_SLOTS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [3:0]        in_operation,
  input  wire logic [AW-1:0]     in_address,
  input  wire logic [NW-1:0]     in_slot_index,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [NW-1:0]          out_slot_number,
  output logic [AW-1:0]          out_slot_address,
  output logic [CW-1:0]          out_freed_count,
  output logic [CW-1:0]          out_live_count,
  output logic [CW-1:0]          out_free_count,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [AW-1:0]     cfg_data
);

  spa_cmd_t  cmd;
  spa_stat_t stat;

  assign cfg_ready = 1'b1;

  spa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  spa_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_operation),
    .in_address       (in_address),
    .in_slot_index    (in_slot_index),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot_number  (out_slot_number),
    .out_slot_address (out_slot_address),
    .out_freed_count  (out_freed_count),
    .out_live_count   (out_live_count),
    .out_free_count   (out_free_count)
  );

endmodule
`default_nettype wire
